FILE: rtl/quadratic_probe_hash_table_assert.svh
// assertion macros for the quadratic probe hash table
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define QPHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QPHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qpht_pkg.sv
package qpht_pkg;

   localparam int TABLE_SIZE_DEF = 8192;
   localparam int KEY_BITS_DEF   = 64;
   localparam int MAX_PROBES_DEF = 8192;

   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int HOME_W    = 13;
   localparam int KEY_W     = 64;
   localparam int OFFSET_W  = 19;
   localparam int COUNT_W   = 10;
   localparam int ENTRY_W   = 14;
   localparam int PAYLOAD_W = 2 * OFFSET_W + COUNT_W;
   localparam int SHIFT_W   = 4;

   localparam logic [OFFSET_W-1:0] OFFSET_HIGH_MASK = 19'h70000;
   localparam logic [COUNT_W-1:0]  COUNT_HIGH_MASK  = 10'h300;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR,
      CMD_INSERT,
      CMD_LOOKUP,
      CMD_NOP
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE,
      STAT_FOUND,
      STAT_NOT_FOUND,
      STAT_FULL
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_REDUCE,
      ST_CHECK,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       reduce;
      logic       home;
      logic       step;
      logic       write;
      logic       sweep;
      logic       clear_regs;
      logic       finish;
      status_type status;
   } ctl_cmd_type;

   typedef struct packed {
      logic        home_ready;
      logic        sweep_last;
      logic        table_full;
      logic        probes_done;
      logic        rd_valid;
      logic        key_hit;
      command_type op;
   } dp_stat_type;

   // largest shift of the table size that still fits below the home range
   function automatic int reduce_shift(int t);
      int r;
      r = 0;
      for (int j = HOME_W - 1; j >= 0; j--) begin
         if (r == 0 && (t << j) < (1 << HOME_W)) begin
            r = j;
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/qpht_ctrl.sv
module qpht_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  qpht_pkg::command_type command,
   input  qpht_pkg::dp_stat_type stat,
   output qpht_pkg::ctl_cmd_type cmd,
   output logic                 busy
);
   import qpht_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.status = STAT_DONE;
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (command)
                  CMD_CLEAR: begin
                     cmd.clear_regs = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  CMD_INSERT: begin
                     if (stat.table_full) begin
                        cmd.finish = 1'b1;
                        cmd.status = STAT_FULL;
                     end else begin
                        state_in = ST_REDUCE;
                     end
                  end
                  CMD_LOOKUP: state_in = ST_REDUCE;
                  default: cmd.finish = 1'b1;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_REDUCE: begin
            if (stat.home_ready) begin
               cmd.home = 1'b1;
               state_in = ST_CHECK;
            end else begin
               cmd.reduce = 1'b1;
            end
         end
         ST_CHECK: begin
            if (stat.op == CMD_INSERT) begin
               if (!stat.rd_valid) begin
                  state_in = ST_WRITE;
               end else if (stat.probes_done) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_FULL;
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end else begin
               if (stat.key_hit) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_FOUND;
                  state_in = ST_IDLE;
               end else if (!stat.rd_valid || stat.probes_done) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_NOT_FOUND;
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         ST_WRITE: begin
            cmd.write  = 1'b1;
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/qpht_datapath.sv
module qpht_datapath #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BITS   = qpht_pkg::KEY_BITS_DEF,
   parameter int MAX_PROBES = qpht_pkg::MAX_PROBES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qpht_pkg::ctl_cmd_type         cmd,
   input  logic [qpht_pkg::CMD_W-1:0]    req_command,
   input  logic [qpht_pkg::HOME_W-1:0]   req_home_slot,
   input  logic [qpht_pkg::KEY_W-1:0]    req_key,
   input  logic [qpht_pkg::OFFSET_W-1:0] req_name_offset,
   input  logic [qpht_pkg::OFFSET_W-1:0] req_list_offset,
   input  logic [qpht_pkg::COUNT_W-1:0]  req_node_count,
   output qpht_pkg::dp_stat_type         stat,
   output logic                          rsp_strobe,
   output logic [qpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [qpht_pkg::HOME_W-1:0]   rsp_slot,
   output logic [qpht_pkg::OFFSET_W-1:0] rsp_found_name_offset,
   output logic [qpht_pkg::OFFSET_W-1:0] rsp_found_list_offset,
   output logic [qpht_pkg::COUNT_W-1:0]  rsp_found_node_count,
   output logic [qpht_pkg::ENTRY_W-1:0]  rsp_entry_count,
   output logic                          rsp_narrow_only
);
   import qpht_pkg::*;

   localparam int AW     = $clog2(TABLE_SIZE);
   localparam int RW     = (AW > HOME_W) ? AW : HOME_W;
   localparam int CW     = $clog2(TABLE_SIZE + 1);
   localparam int NW     = $clog2(MAX_PROBES + 1);
   localparam int WORD_W = 2 + KEY_BITS + PAYLOAD_W;
   localparam int RED_SHIFT = reduce_shift(TABLE_SIZE);
   localparam logic [AW:0] TS = (AW + 1)'(TABLE_SIZE);

   logic [WORD_W-1:0] mem [TABLE_SIZE];

   command_type         op_ff;
   logic [RW-1:0]       home_ff, home_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [KEY_BITS-1:0] key_ff;
   logic [OFFSET_W-1:0] noff_ff, loff_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       sq_ff, sq_in, inc_ff, inc_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [CW-1:0]       held_ff, held_in;
   logic                narrow_ff, narrow_in;
   logic [AW-1:0]       sweep_ff, sweep_in;
   logic [WORD_W-1:0]   rd_ff;
   logic                strobe_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [HOME_W-1:0]   slot_ff;
   logic [OFFSET_W-1:0] fno_ff, flo_ff;
   logic [COUNT_W-1:0]  fnc_ff;
   logic [ENTRY_W-1:0]  entry_ff;

   logic [31:0]         sub_val;
   logic [AW:0]         sq_sum, inc_sum, up_sum, dn_sum;
   logic [AW-1:0]       sq_plus, inc_plus, home_idx;
   logic                at_home, rd_en, high_bits;
   logic [PAYLOAD_W-1:0] rd_payload;
   logic [KEY_BITS-1:0] rd_key;

   assign home_idx   = home_ff[AW-1:0];
   assign at_home    = (n_ff == '0);
   assign rd_en      = cmd.home | cmd.step;
   assign rd_payload = rd_ff[PAYLOAD_W-1:0];
   assign rd_key     = rd_ff[PAYLOAD_W +: KEY_BITS];
   assign high_bits  = |(noff_ff & OFFSET_HIGH_MASK) | |(loff_ff & OFFSET_HIGH_MASK)
                     | |(cnt_ff & COUNT_HIGH_MASK);

   // home slot modulo table size, one shifted subtract per cycle
   always_comb begin
      sub_val  = 32'(TABLE_SIZE) << shift_ff;
      home_in  = home_ff;
      shift_in = shift_ff;
      if (cmd.load) begin
         home_in  = RW'(req_home_slot);
         shift_in = SHIFT_W'(RED_SHIFT);
      end else if (cmd.reduce) begin
         if (32'(home_ff) >= sub_val) begin
            home_in = RW'(32'(home_ff) - sub_val);
         end
         if (shift_ff != '0) begin
            shift_in = shift_ff - 1'b1;
         end
      end
   end

   // probe sequence: squares kept by running odd increments
   always_comb begin
      sq_sum   = {1'b0, sq_ff} + {1'b0, inc_ff};
      sq_plus  = (sq_sum >= TS) ? AW'(sq_sum - TS) : sq_sum[AW-1:0];
      inc_sum  = {1'b0, inc_ff} + (AW + 1)'(2);
      inc_plus = (inc_sum >= TS) ? AW'(inc_sum - TS) : inc_sum[AW-1:0];
      up_sum   = {1'b0, home_idx} + {1'b0, sq_plus};
      dn_sum   = {1'b0, home_idx} + TS - {1'b0, sq_ff};
      addr_in  = addr_ff;
      sq_in    = sq_ff;
      inc_in   = inc_ff;
      n_in     = n_ff;
      if (cmd.home) begin
         addr_in = home_idx;
         sq_in   = '0;
         inc_in  = AW'(1);
         n_in    = '0;
      end else if (cmd.step) begin
         n_in = n_ff + 1'b1;
         if (!n_ff[0]) begin
            sq_in   = sq_plus;
            inc_in  = inc_plus;
            addr_in = (up_sum >= TS) ? AW'(up_sum - TS) : up_sum[AW-1:0];
         end else begin
            addr_in = (dn_sum >= TS) ? AW'(dn_sum - TS) : dn_sum[AW-1:0];
         end
      end
   end

   always_comb begin
      held_in   = held_ff;
      narrow_in = narrow_ff;
      sweep_in  = sweep_ff;
      if (cmd.clear_regs) begin
         held_in   = '0;
         narrow_in = 1'b1;
      end else if (cmd.write) begin
         held_in = held_ff + 1'b1;
         if (high_bits) begin
            narrow_in = 1'b0;
         end
      end
      if (cmd.sweep) begin
         sweep_in = stat.sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         narrow_ff <= 1'b1;
         sweep_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         held_ff   <= held_in;
         narrow_ff <= narrow_in;
         sweep_ff  <= sweep_in;
         strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= command_type'(req_command);
         key_ff  <= req_key[KEY_BITS-1:0];
         noff_ff <= req_name_offset;
         loff_ff <= req_list_offset;
         cnt_ff  <= req_node_count;
      end
      home_ff  <= home_in;
      shift_ff <= shift_in;
      addr_ff  <= addr_in;
      sq_ff    <= sq_in;
      inc_ff   <= inc_in;
      n_ff     <= n_in;
      if (cmd.finish) begin
         status_ff <= cmd.status;
         slot_ff   <= (cmd.write || cmd.status == STAT_FOUND) ? HOME_W'(addr_ff) : '0;
         fno_ff    <= (cmd.status == STAT_FOUND) ? rd_payload[OFFSET_W-1:0] : '0;
         flo_ff    <= (cmd.status == STAT_FOUND) ? rd_payload[OFFSET_W +: OFFSET_W] : '0;
         fnc_ff    <= (cmd.status == STAT_FOUND) ? rd_payload[2*OFFSET_W +: COUNT_W] : '0;
         entry_ff  <= ENTRY_W'(held_in);
      end
   end

   // table storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         mem[sweep_ff] <= '0;
      end else if (cmd.write) begin
         mem[addr_ff] <= {1'b1, at_home, key_ff, cnt_ff, loff_ff, noff_ff};
      end
      if (rd_en) begin
         rd_ff <= mem[addr_in];
      end
   end

   always_comb begin
      stat.home_ready  = (32'(home_ff) < 32'(TABLE_SIZE));
      stat.sweep_last  = (sweep_ff == AW'(TABLE_SIZE - 1));
      stat.table_full  = (held_ff == CW'(TABLE_SIZE));
      stat.probes_done = (n_ff == NW'(MAX_PROBES));
      stat.rd_valid    = rd_ff[WORD_W-1];
      stat.key_hit     = rd_ff[WORD_W-1] && (rd_key == key_ff) && (rd_ff[WORD_W-2] == at_home);
      stat.op          = op_ff;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_status            = status_ff;
   assign rsp_slot              = slot_ff;
   assign rsp_found_name_offset = fno_ff;
   assign rsp_found_list_offset = flo_ff;
   assign rsp_found_node_count  = fnc_ff;
   assign rsp_entry_count       = entry_ff;
   assign rsp_narrow_only       = narrow_ff;

endmodule

FILE: rtl/quadratic_probe_hash_table.sv
// channel   ports                               handshake
// request   req_command .. req_node_count       accepted when start and not busy
// response  rsp_status .. rsp_narrow_only       one cycle, marked by rsp_strobe
//
// after reset a sweep clears the table while busy is high
// insert or lookup: accept, reduce steps when the home range exceeds TABLE_SIZE,
// a home read, a check per slot (home and each probe), a write on a stored insert
// clear: accept, then a sweep of the table; no-op and full-table insert answer at accept
// each result beat is shown for one cycle after the command ends; no stall
module quadratic_probe_hash_table #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BITS   = qpht_pkg::KEY_BITS_DEF,
   parameter int MAX_PROBES = qpht_pkg::MAX_PROBES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [qpht_pkg::CMD_W-1:0]    req_command,
   input  logic [qpht_pkg::HOME_W-1:0]   req_home_slot,
   input  logic [qpht_pkg::KEY_W-1:0]    req_key,
   input  logic [qpht_pkg::OFFSET_W-1:0] req_name_offset,
   input  logic [qpht_pkg::OFFSET_W-1:0] req_list_offset,
   input  logic [qpht_pkg::COUNT_W-1:0]  req_node_count,
   output logic                          rsp_strobe,
   output logic [qpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [qpht_pkg::HOME_W-1:0]   rsp_slot,
   output logic [qpht_pkg::OFFSET_W-1:0] rsp_found_name_offset,
   output logic [qpht_pkg::OFFSET_W-1:0] rsp_found_list_offset,
   output logic [qpht_pkg::COUNT_W-1:0]  rsp_found_node_count,
   output logic [qpht_pkg::ENTRY_W-1:0]  rsp_entry_count,
   output logic                          rsp_narrow_only
);
   import qpht_pkg::*;
   `include "quadratic_probe_hash_table_assert.svh"

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   qpht_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (command_type'(req_command)),
      .stat    (dp_stat),
      .cmd     (ctl_cmd),
      .busy    (busy)
   );

   qpht_datapath #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS),
      .MAX_PROBES (MAX_PROBES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (ctl_cmd),
      .req_command           (req_command),
      .req_home_slot         (req_home_slot),
      .req_key               (req_key),
      .req_name_offset       (req_name_offset),
      .req_list_offset       (req_list_offset),
      .req_node_count        (req_node_count),
      .stat                  (dp_stat),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_found_name_offset (rsp_found_name_offset),
      .rsp_found_list_offset (rsp_found_list_offset),
      .rsp_found_node_count  (rsp_found_node_count),
      .rsp_entry_count       (rsp_entry_count),
      .rsp_narrow_only       (rsp_narrow_only)
   );

   `QPHT_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe, "accepted command made no progress")
   `QPHT_ASSERT_NEXT(a_write_reports, clock, reset, ctl_cmd.write, rsp_strobe && rsp_status == STAT_DONE, "stored insert not reported")
   `QPHT_ASSERT_NOW(a_miss_no_payload, clock, reset, rsp_strobe && rsp_status != STAT_FOUND, rsp_found_name_offset == '0 && rsp_found_list_offset == '0 && rsp_found_node_count == '0, "found fields set on a miss")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import qpht_pkg::*;

   localparam int SLOTS = 8192;
   localparam int PROBES = 8192;
   localparam longint CYCLE_LIMIT = 20000000;

   typedef struct {
      status_type           status;
      logic [HOME_W-1:0]    slot;
      logic [OFFSET_W-1:0]  name_ofs;
      logic [OFFSET_W-1:0]  list_ofs;
      logic [COUNT_W-1:0]   count;
      logic [ENTRY_W-1:0]   entries;
      logic                 narrow;
   } outcome_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [CMD_W-1:0] req_command = '0;
   logic [HOME_W-1:0] req_home_slot = '0;
   logic [KEY_W-1:0] req_key = '0;
   logic [OFFSET_W-1:0] req_name_offset = '0;
   logic [OFFSET_W-1:0] req_list_offset = '0;
   logic [COUNT_W-1:0] req_node_count = '0;
   logic rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [HOME_W-1:0] rsp_slot;
   logic [OFFSET_W-1:0] rsp_found_name_offset;
   logic [OFFSET_W-1:0] rsp_found_list_offset;
   logic [COUNT_W-1:0] rsp_found_node_count;
   logic [ENTRY_W-1:0] rsp_entry_count;
   logic rsp_narrow_only;

   // model of the table
   bit occupied [SLOTS];
   bit home_entry [SLOTS];
   logic [KEY_W-1:0] stored_key [SLOTS];
   logic [PAYLOAD_W-1:0] stored_payload [SLOTS];
   int unsigned held_count;
   bit narrow_state;

   outcome_type expected_outcomes[$];
   logic [KEY_W-1:0] known_keys[$];
   logic [HOME_W-1:0] known_homes[$];
   logic [HOME_W-1:0] hot_homes[8];

   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int cmd_seen [4];
   int stat_seen [4];
   longint cycles = 0;
   bit no_idle = 0;

   always #2 clock = ~clock;

   quadratic_probe_hash_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_home_slot(req_home_slot), .req_key(req_key),
      .req_name_offset(req_name_offset), .req_list_offset(req_list_offset),
      .req_node_count(req_node_count), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_found_name_offset(rsp_found_name_offset),
      .rsp_found_list_offset(rsp_found_list_offset),
      .rsp_found_node_count(rsp_found_node_count), .rsp_entry_count(rsp_entry_count),
      .rsp_narrow_only(rsp_narrow_only)
   );

   function automatic int unsigned probe_at(int unsigned home, int unsigned n);
      int unsigned d, sq;
      d = (n + 1) / 2;
      sq = (d * d) % SLOTS;
      if (n & 1) return (home + sq) % SLOTS;
      return (home + SLOTS - sq) % SLOTS;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         occupied[i] = 0;
         home_entry[i] = 0;
      end
      held_count = 0;
      narrow_state = 1;
   endfunction

   function automatic outcome_type table_outcome(command_type cmd, logic [HOME_W-1:0] home,
         logic [KEY_W-1:0] key, logic [OFFSET_W-1:0] noff, logic [OFFSET_W-1:0] loff,
         logic [COUNT_W-1:0] cnt);
      outcome_type o;
      int unsigned at;
      int hit;
      bit placed, at_home;
      o.status = STAT_DONE;
      o.slot = '0;
      o.name_ofs = '0;
      o.list_ofs = '0;
      o.count = '0;
      case (cmd)
         CMD_CLEAR: wipe_table();
         CMD_INSERT: begin
            placed = 0;
            at = home;
            at_home = 1;
            if (held_count < SLOTS) begin
               if (!occupied[home]) begin
                  placed = 1;
               end else begin
                  at_home = 0;
                  for (int n = 1; n <= PROBES && !placed; n++) begin
                     at = probe_at(home, n);
                     if (!occupied[at]) placed = 1;
                  end
               end
            end
            if (placed) begin
               occupied[at] = 1;
               home_entry[at] = at_home;
               stored_key[at] = key;
               stored_payload[at] = {cnt, loff, noff};
               held_count++;
               if ((noff & OFFSET_HIGH_MASK) != 0 || (loff & OFFSET_HIGH_MASK) != 0 ||
                   (cnt & COUNT_HIGH_MASK) != 0)
                  narrow_state = 0;
               o.slot = HOME_W'(at);
            end else begin
               o.status = STAT_FULL;
            end
         end
         CMD_LOOKUP: begin
            hit = -1;
            if (occupied[home]) begin
               if (home_entry[home] && stored_key[home] == key) begin
                  hit = home;
               end else begin
                  for (int n = 1; n <= PROBES; n++) begin
                     at = probe_at(home, n);
                     if (!occupied[at]) break;
                     if (!home_entry[at] && stored_key[at] == key) begin
                        hit = at;
                        break;
                     end
                  end
               end
            end
            if (hit >= 0) begin
               o.status = STAT_FOUND;
               o.slot = HOME_W'(hit);
               {o.count, o.list_ofs, o.name_ofs} = stored_payload[hit];
            end else begin
               o.status = STAT_NOT_FOUND;
            end
         end
         default: ;
      endcase
      o.entries = ENTRY_W'(held_count);
      o.narrow = narrow_state;
      return o;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("mismatch %s: got %0h expected %0h (beat %0d)", what, got, want, beats_checked);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected beat, status", rsp_status, 0);
         end else begin
            e = expected_outcomes.pop_front();
            stat_seen[rsp_status]++;
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_slot !== e.slot) report_mismatch("slot", rsp_slot, e.slot);
            if (rsp_found_name_offset !== e.name_ofs)
               report_mismatch("name offset", rsp_found_name_offset, e.name_ofs);
            if (rsp_found_list_offset !== e.list_ofs)
               report_mismatch("list offset", rsp_found_list_offset, e.list_ofs);
            if (rsp_found_node_count !== e.count)
               report_mismatch("node count", rsp_found_node_count, e.count);
            if (rsp_entry_count !== e.entries)
               report_mismatch("entry count", rsp_entry_count, e.entries);
            if (rsp_narrow_only !== e.narrow)
               report_mismatch("narrow flag", rsp_narrow_only, e.narrow);
            beats_checked++;
         end
      end
   end

   task automatic send_beat(command_type cmd, logic [HOME_W-1:0] home, logic [KEY_W-1:0] key,
         logic [OFFSET_W-1:0] noff = '0, logic [OFFSET_W-1:0] loff = '0,
         logic [COUNT_W-1:0] cnt = '0);
      start <= 1;
      req_command <= cmd;
      req_home_slot <= home;
      req_key <= key;
      req_name_offset <= noff;
      req_list_offset <= loff;
      req_node_count <= cnt;
      do @(posedge clock); while (busy);
      expected_outcomes.push_back(table_outcome(cmd, home, key, noff, loff, cnt));
      cmd_seen[cmd]++;
      beats_sent++;
      if (cmd == CMD_INSERT) begin
         known_keys.push_back(key);
         known_homes.push_back(home);
      end
      if (cmd == CMD_CLEAR) begin
         known_keys.delete();
         known_homes.delete();
      end
   endtask

   task automatic idle_gap();
      int r, n;
      r = $urandom_range(99);
      n = 0;
      if (!no_idle) begin
         if (r < 30) n = $urandom_range(3, 1);
         else if (r < 38) n = $urandom_range(40, 10);
      end
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_directed();
      send_beat(CMD_NOP, '1, '1, '1, '1, '1);
      send_beat(CMD_LOOKUP, 13'd100, 64'h1234);
      send_beat(CMD_INSERT, 13'd8191, '1, '1, '1, '1);
      send_beat(CMD_LOOKUP, 13'd8191, '1);
      send_beat(CMD_INSERT, '0, '0);
      idle_gap();
      send_beat(CMD_INSERT, '0, 64'haaaa_5555_aaaa_5555, 19'h0ffff, 19'h0ffff, 10'h0ff);
      send_beat(CMD_INSERT, '0, 64'h5555_aaaa_5555_aaaa, 19'h12345, 19'h54321, 10'h155);
      send_beat(CMD_INSERT, '0, 64'h1, 19'h1, 19'h2, 10'h3);
      send_beat(CMD_LOOKUP, '0, 64'h1);
      send_beat(CMD_LOOKUP, '0, 64'h5555_aaaa_5555_aaaa);
      send_beat(CMD_LOOKUP, '0, 64'haaaa_5555_aaaa_5555);
      send_beat(CMD_LOOKUP, '0, '0);
      send_beat(CMD_LOOKUP, '0, 64'h77);
      // a probed key that lands on a neighbour's home slot must not match from that home
      send_beat(CMD_LOOKUP, 13'd1, 64'haaaa_5555_aaaa_5555);
      send_beat(CMD_NOP, 13'd5, 64'h9);
      send_beat(CMD_CLEAR, '0, '0);
      send_beat(CMD_LOOKUP, '0, 64'h1);
      send_beat(CMD_INSERT, 13'd4000, 64'h42, 19'h7ffff, 19'h0, 10'h0);
      send_beat(CMD_LOOKUP, 13'd4000, 64'h42);
      drain();
   endtask

   // long probe chains from one crowded home slot
   task automatic test_crowded_home();
      int k;
      no_idle = 1;
      send_beat(CMD_CLEAR, '0, '0);
      for (int i = 0; i < 150; i++)
         send_beat(CMD_INSERT, '0, rand_key(), OFFSET_W'($urandom), OFFSET_W'($urandom),
            COUNT_W'($urandom));
      for (int i = 0; i < 40; i++) begin
         k = $urandom_range(known_keys.size() - 1);
         send_beat(CMD_LOOKUP, '0, known_keys[k]);
      end
      send_beat(CMD_LOOKUP, '0, 64'hdead);
      send_beat(CMD_LOOKUP, 13'd8191, known_keys[known_keys.size()-1]);
      send_beat(CMD_CLEAR, '0, '0);
      no_idle = 0;
      drain();
   endtask

   task automatic test_random(int count);
      int r, k;
      logic [HOME_W-1:0] home;
      logic [KEY_W-1:0] key;
      logic [OFFSET_W-1:0] noff, loff;
      logic [COUNT_W-1:0] cnt;
      for (int i = 0; i < 8; i++) hot_homes[i] = HOME_W'($urandom);
      hot_homes[0] = '0;
      hot_homes[1] = 13'd8191;
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 100) no_idle = 1;
         if (i % 200 == 150) no_idle = 0;
         if (i == count / 2) drain();
         r = $urandom_range(999);
         home = ($urandom_range(1)) ? hot_homes[$urandom_range(7)] : HOME_W'($urandom);
         key = rand_key();
         noff = OFFSET_W'($urandom);
         loff = OFFSET_W'($urandom);
         cnt = COUNT_W'($urandom);
         if ($urandom_range(3) != 0) begin
            noff[18:16] = 0;
            loff[18:16] = 0;
            cnt[9:8] = 0;
         end
         if (r < 8) begin
            send_beat(CMD_CLEAR, home, key, noff, loff, cnt);
         end else if (r < 25) begin
            send_beat(CMD_NOP, home, key, noff, loff, cnt);
         end else if (r < 520) begin
            if (known_keys.size() != 0 && $urandom_range(4) == 0)
               key = known_keys[$urandom_range(known_keys.size() - 1)];
            send_beat(CMD_INSERT, home, key, noff, loff, cnt);
         end else begin
            if (known_keys.size() != 0 && $urandom_range(9) < 6) begin
               k = $urandom_range(known_keys.size() - 1);
               key = known_keys[k];
               if ($urandom_range(4) != 0) home = known_homes[k];
            end
            send_beat(CMD_LOOKUP, home, key, noff, loff, cnt);
         end
         idle_gap();
      end
      drain();
   endtask

   initial begin
      wipe_table();
      repeat (7) @(posedge clock);
      reset <= 0;
      test_directed();
      test_crowded_home();
      test_random(736);
      $display("%0d beats sent: %0d clear, %0d insert, %0d lookup, %0d no-op",
         beats_sent, cmd_seen[CMD_CLEAR], cmd_seen[CMD_INSERT], cmd_seen[CMD_LOOKUP],
         cmd_seen[CMD_NOP]);
      $display("results: %0d done, %0d found, %0d not found, %0d full, %0d errors",
         stat_seen[STAT_DONE], stat_seen[STAT_FOUND], stat_seen[STAT_NOT_FOUND],
         stat_seen[STAT_FULL], errors);
      if (errors == 0 && expected_outcomes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/qpht_pkg.sv
rtl/qpht_ctrl.sv
rtl/qpht_datapath.sv
rtl/quadratic_probe_hash_table.sv
tb/tb_top.sv
